// ----- rtl/rttws_pkg.sv -----
// ----------------------------------------------------------------------------
// RTT window statistics package
// Shared widths, defaults and request codes for the RTT window statistics
// block and its sub-modules.
// ----------------------------------------------------------------------------
package rttws_pkg;

    // Default window capacity in samples.
    localparam int MAX_SAMPLES_DEF = 64;

    // Field widths of requests and results.
    localparam int RTT_W         = 16;
    localparam int COUNT_OUT_W   = 7;
    localparam int Q8_W          = 24;
    localparam int FRAC_W        = 8;

    // Result payload packing: count, min, max, mean, deviation.
    localparam int OUT_FIELDS_W  = COUNT_OUT_W + 2 * RTT_W + 2 * Q8_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W   = 2;

    // Request kinds carried on the input tuser bit.
    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_CLOSE = 1'b1
    } op_t;

endpackage

// ----- rtl/rttws_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module rttws_ram #(
    parameter int WIDTH = rttws_pkg::RTT_W,
    parameter int DEPTH = rttws_pkg::MAX_SAMPLES_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/rttws_div.sv -----
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring long division, one quotient bit per cycle. The caller guarantees
// that the quotient fits in QUO_W bits, so the upper dividend bits start as
// the partial remainder.
// ----------------------------------------------------------------------------
module rttws_div #(
    parameter int DIVISOR_W = 14,
    parameter int QUO_W     = rttws_pkg::Q8_W,
    parameter int DIVIDEND_W = DIVISOR_W + QUO_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [QUO_W-1:0]      quotient,
    output logic                  done
);

    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]     num_reg, num_next;
    logic [DIVISOR_W-1:0] den_reg, den_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;

    // One division step: shift in the next dividend bit and try a subtract.
    always_comb begin
        trial = {rem_reg, num_reg[QUO_W-1]};
        diff  = trial - {1'b0, den_reg};
    end

    always_comb begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend[DIVIDEND_W-1:QUO_W];
            num_next  = dividend[QUO_W-1:0];
            den_next  = divisor;
            step_next = STEP_W'(QUO_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DIVISOR_W]) begin
                rem_next = diff[DIVISOR_W-1:0];
                num_next = {num_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
                num_next = {num_reg[QUO_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        step_reg <= step_next;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = num_reg;
    assign done     = done_reg;

endmodule

// ----- rtl/rtt_window_statistics_core.sv -----
// ----------------------------------------------------------------------------
// RTT window statistics core
// Collects round-trip-time samples of one ping window in a sample RAM and, on
// a close request, reports count, minimum, maximum, mean and mean absolute
// deviation (both in Q8), then clears the window.
//
// Input channel s_*: s_tdata carries rtt_ms, s_tuser[0] the request kind
// (add sample or close window). Output channel m_*: one result per close.
// An add request gives no result; once the window holds MAX_SAMPLES samples
// further adds are dropped and flagged on the next close. After acceptance, a
// close request of a window with n samples scans the sample RAM at one read
// per cycle, two runs of the shared bit-serial divider give the mean and the
// deviation, and the output register is loaded. An empty window skips the
// scan and the divider and goes straight to loading the output register.
// s_tready is low while a close is in work.
// The result sits in an output register; a stalled receiver does not block
// add requests, but a following close waits at its end for the register.
// Reset clears the window count, sum and drop flag; the RAM is not cleared.
// ----------------------------------------------------------------------------
module rtt_window_statistics_core #(
    parameter int MAX_SAMPLES = rttws_pkg::MAX_SAMPLES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input requests.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rttws_pkg::RTT_W-1:0]        s_tdata,  // [15:0] rtt_ms
    input  logic [0:0]                         s_tuser,  // [0] operation
    // Results.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [6:0] sample_count, [22:7] min_rtt_ms, [38:23] max_rtt_ms,
    // [62:39] mean_rtt_q8, [86:63] mean_abs_dev_q8, [87] zero
    output logic [rttws_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic [rttws_pkg::OUT_TUSER_W-1:0]  m_tuser   // [0] no_response, [1] overflowed
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int RTT_W  = rttws_pkg::RTT_W;
    localparam int SUM_W  = RTT_W + CNT_W;
    localparam int ABS_W  = RTT_W + 2 * CNT_W;
    localparam int NSQ_W  = 2 * CNT_W;
    localparam int Q8_W   = rttws_pkg::Q8_W;
    localparam int DIV_W  = NSQ_W + Q8_W;
    localparam int COUT_W = rttws_pkg::COUNT_OUT_W;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_SCAN      = 7'b0000010,
        ST_MEAN      = 7'b0000100,
        ST_MEAN_WAIT = 7'b0001000,
        ST_DEV       = 7'b0010000,
        ST_DEV_WAIT  = 7'b0100000,
        ST_FINISH    = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  dropped_reg, dropped_next;
    logic [CNT_W-1:0]      issue_reg, issue_next;
    logic                  rd_v1_reg, rd_v1_next;
    logic                  rd_v2_reg, rd_v2_next;
    logic [SUM_W-1:0]      prod_reg, prod_next;
    logic [RTT_W-1:0]      min_reg, min_next;
    logic [RTT_W-1:0]      max_reg, max_next;
    logic [ABS_W-1:0]      abs_reg, abs_next;
    logic [NSQ_W-1:0]      nsq_reg, nsq_next;
    logic [Q8_W-1:0]       mean_reg, mean_next;
    logic [Q8_W-1:0]       dev_reg, dev_next;
    logic                  m_valid_reg, m_valid_next;
    logic [rttws_pkg::OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [rttws_pkg::OUT_TUSER_W-1:0] m_user_reg, m_user_next;

    logic                  in_acc;
    rttws_pkg::op_t        in_op;
    logic                  wr_en;
    logic                  rd_en;
    logic [RTT_W-1:0]      rd_data;
    logic [SUM_W-1:0]      abs_diff;
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [NSQ_W-1:0]      div_divisor;
    logic [Q8_W-1:0]       div_quo;
    logic                  div_done;
    logic                  out_free;
    logic                  empty;
    logic [COUT_W+CNT_W-1:0] count_ext;

    // Input handshake and request decode.
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_op    = rttws_pkg::op_t'(s_tuser[0]);

    // Sample store.
    rttws_ram #(
        .WIDTH (RTT_W),
        .DEPTH (MAX_SAMPLES),
        .ADDR_W(IDX_W)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(count_reg[IDX_W-1:0]),
        .wr_data(s_tdata),
        .rd_en  (rd_en),
        .rd_addr(issue_reg[IDX_W-1:0]),
        .rd_data(rd_data)
    );

    // Shared divider for the mean and the deviation.
    rttws_div #(
        .DIVISOR_W (NSQ_W),
        .QUO_W     (Q8_W),
        .DIVIDEND_W(DIV_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .quotient(div_quo),
        .done    (div_done)
    );

    // Absolute distance of n*x from the window sum.
    assign abs_diff = (prod_reg >= sum_reg) ? (prod_reg - sum_reg) : (sum_reg - prod_reg);

    // Divider operands: sum/n for the mean, abs_total/n^2 for the deviation.
    assign div_start    = (state_reg == ST_MEAN) || (state_reg == ST_DEV);
    assign div_dividend = (state_reg == ST_MEAN)
                          ? DIV_W'({sum_reg, {rttws_pkg::FRAC_W{1'b0}}})
                          : {abs_reg, {rttws_pkg::FRAC_W{1'b0}}};
    assign div_divisor  = (state_reg == ST_MEAN) ? NSQ_W'(count_reg) : nsq_reg;

    assign out_free  = !m_valid_reg || m_tready;
    assign empty     = (count_reg == '0);
    assign count_ext = {{COUT_W{1'b0}}, count_reg};

    // Main control and datapath.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        dropped_next = dropped_reg;
        issue_next   = issue_reg;
        rd_v1_next   = 1'b0;
        rd_v2_next   = rd_v1_reg;
        prod_next    = prod_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        abs_next     = abs_reg;
        nsq_next     = nsq_reg;
        mean_next    = mean_reg;
        dev_next     = dev_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        // The receiver empties the output register.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_op == rttws_pkg::OP_ADD) begin
                        if (count_reg < CNT_W'(MAX_SAMPLES)) begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            sum_next   = sum_reg + SUM_W'(s_tdata);
                        end else begin
                            dropped_next = 1'b1;
                        end
                    end else begin
                        issue_next = '0;
                        min_next   = '1;
                        max_next   = '0;
                        abs_next   = '0;
                        mean_next  = '0;
                        dev_next   = '0;
                        nsq_next   = NSQ_W'(count_reg) * NSQ_W'(count_reg);
                        state_next = empty ? ST_FINISH : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Stage 0: issue reads in order.
                if (issue_reg < count_reg) begin
                    rd_en      = 1'b1;
                    rd_v1_next = 1'b1;
                    issue_next = issue_reg + CNT_W'(1);
                end
                // Stage 1: read data back, track extremes, scale by n.
                if (rd_v1_reg) begin
                    prod_next = SUM_W'(count_reg) * SUM_W'(rd_data);
                    if (rd_data < min_reg) begin
                        min_next = rd_data;
                    end
                    if (rd_data > max_reg) begin
                        max_next = rd_data;
                    end
                end
                // Stage 2: accumulate the absolute deviation.
                if (rd_v2_reg) begin
                    abs_next = abs_reg + ABS_W'(abs_diff);
                end
                if (issue_reg == count_reg && !rd_v1_reg && !rd_v2_reg) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN: begin
                state_next = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (div_done) begin
                    mean_next  = div_quo;
                    state_next = ST_DEV;
                end
            end
            ST_DEV: begin
                state_next = ST_DEV_WAIT;
            end
            ST_DEV_WAIT: begin
                if (div_done) begin
                    dev_next   = div_quo;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hand the result over once the output register is free.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = rttws_pkg::OUT_TDATA_W'({
                        dev_reg,
                        mean_reg,
                        empty ? {RTT_W{1'b0}} : max_reg,
                        empty ? {RTT_W{1'b0}} : min_reg,
                        count_ext[COUT_W-1:0]
                    });
                    m_user_next  = {dropped_reg, empty};
                    count_next   = '0;
                    sum_next     = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            sum_reg     <= '0;
            dropped_reg <= 1'b0;
            rd_v1_reg   <= 1'b0;
            rd_v2_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            dropped_reg <= dropped_next;
            rd_v1_reg   <= rd_v1_next;
            rd_v2_reg   <= rd_v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        issue_reg  <= issue_next;
        prod_reg   <= prod_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        abs_reg    <= abs_next;
        nsq_reg    <= nsq_next;
        mean_reg   <= mean_next;
        dev_reg    <= dev_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // The window never holds more samples than the store has entries.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("window count exceeds store capacity");

    // The scan reads only entries written in the current window.
    a_read_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (issue_reg < count_reg))
        else $error("sample read beyond the stored count");

    // A finished result is held back while the previous one is stalled.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && m_valid_reg && !m_tready) |=> (state_reg == ST_FINISH))
        else $error("result overwrote a stalled output");

    // A close request always starts the statistics sequence.
    a_close_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && in_op == rttws_pkg::OP_CLOSE) |=> (state_reg != ST_IDLE))
        else $error("close request did not leave idle");
`endif

endmodule
